// ===== hdl/video_start_code_header_parser_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the video start code header parser
// Shorthands for clocked concurrent checks, disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef VIDEO_START_CODE_HEADER_PARSER_CORE_ASSERT_SVH
`define VIDEO_START_CODE_HEADER_PARSER_CORE_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define VSCP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define VSCP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define VSCP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/vscp_pkg.sv =====
// ----------------------------------------------------------------------------
// Video start code header parser package
// Parse phases, unit kinds and the start code values that the parser knows.
// ----------------------------------------------------------------------------
`default_nettype none

package vscp_pkg;

    // Parser phases.
    typedef enum logic [1:0] {
        PH_SCAN = 2'd0,
        PH_CODE = 2'd1,
        PH_SEQ  = 2'd2,
        PH_PIC  = 2'd3
    } phase_t;

    // Reported unit kinds.
    localparam logic [2:0] KIND_SEQ   = 3'd0;
    localparam logic [2:0] KIND_GOP   = 3'd1;
    localparam logic [2:0] KIND_PIC   = 3'd2;
    localparam logic [2:0] KIND_SLICE = 3'd3;
    localparam logic [2:0] KIND_OTHER = 3'd4;

    // Picture coding types.
    localparam logic [1:0] PIC_UNKNOWN = 2'd0;

    // Code bytes and start code prefix values.
    localparam logic [7:0] CODE_SEQ    = 8'hB3;
    localparam logic [7:0] CODE_GOP    = 8'hB8;
    localparam logic [7:0] CODE_PIC    = 8'h00;
    localparam logic [7:0] CODE_SLICE  = 8'h01;
    localparam logic [7:0] BYTE_ZERO   = 8'h00;
    localparam logic [7:0] BYTE_PREFIX = 8'h01;

    // Sequence header payload: bytes stored before the last one arrives.
    localparam logic [1:0] SEQ_STORED  = 2'd3;

    // Frame rate index used for codes outside 1..7 (60 fps).
    localparam logic [2:0] RATE_DEFAULT = 3'd7;

endpackage

`default_nettype wire

// ===== hdl/video_start_code_header_parser_core.sv =====
// ----------------------------------------------------------------------------
// Video start code header parser core
// Scans a video elementary stream for start codes and reports each unit.
// ----------------------------------------------------------------------------
// Usage:
// Bytes of the elementary stream enter on the s_axis channel, one byte per
// transaction. Each recognized unit leaves on the m_axis channel as one
// transaction: tuser carries the unit kind, tdata the code byte and the
// decoded header fields. Sequence headers report width, height and frame rate
// index after their fourth payload byte, picture headers report the coding
// type after their second payload byte, and every other code reports as soon
// as its code byte arrives. Payload bytes are never scanned for start codes.
// A byte is held in the input register and its result is registered in the
// output register. Throughput is one byte per cycle while the receiver keeps
// up, set by the single pass through the parse logic between those
// two registers. When the receiver stalls, the output register holds its
// transaction and the input register still takes one more byte; the channel
// then stops taking bytes until the result is taken. Reset clears the parse
// state to scanning and empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "video_start_code_header_parser_core_assert.svh"

module video_start_code_header_parser_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
    // Unit reports.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [7:0] code_value, [19:8] frame_width,
                                             // [31:20] frame_height, [34:32] rate_index,
                                             // [36:35] picture_kind, [39:37] zero
    output logic [2:0]       m_axis_tuser    // [2:0] unit_kind
);

    import vscp_pkg::*;

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Parse state.
    phase_t     phase_reg, phase_next;
    logic [1:0] zero_run_reg, zero_run_next;
    logic [1:0] count_reg, count_next;
    logic [7:0] payload_reg [3];

    // Output register.
    logic        out_valid_reg;
    logic [2:0]  kind_reg;
    logic [7:0]  code_reg;
    logic [11:0] width_reg;
    logic [11:0] height_reg;
    logic [2:0]  rate_reg;
    logic [1:0]  pic_reg;

    // Combinational parse results.
    logic        res_valid;
    logic [2:0]  res_kind;
    logic [7:0]  res_code;
    logic [11:0] res_width;
    logic [11:0] res_height;
    logic [2:0]  res_rate;
    logic [1:0]  res_pic;
    logic        payload_wr;
    logic        advance;
    logic [7:0]  b;

    // The held byte is parsed when the output register is free or being
    // emptied in this cycle.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign b             = in_byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    // State register of the parser.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SCAN;
            zero_run_reg <= 2'd0;
            count_reg    <= 2'd0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            zero_run_reg <= zero_run_next;
            count_reg    <= count_next;
        end
    end

    // Stored sequence header payload bytes.
    always_ff @(posedge clk)
    begin
        if (advance && payload_wr)
        begin
            payload_reg[count_reg] <= b;
        end
    end

    // Next state and unit report.
    always_comb
    begin
        phase_next    = phase_reg;
        zero_run_next = zero_run_reg;
        count_next    = count_reg;
        payload_wr    = 1'b0;
        res_valid     = 1'b0;
        res_kind      = KIND_OTHER;
        res_code      = b;
        res_width     = 12'd0;
        res_height    = 12'd0;
        res_rate      = 3'd0;
        res_pic       = PIC_UNKNOWN;

        unique case (phase_reg)
            PH_CODE:
            begin
                zero_run_next = 2'd0;
                count_next    = 2'd0;
                if (b == CODE_SEQ)
                begin
                    phase_next = PH_SEQ;
                end
                else if (b == CODE_PIC)
                begin
                    phase_next = PH_PIC;
                end
                else
                begin
                    phase_next = PH_SCAN;
                    res_valid  = 1'b1;
                    if (b == CODE_GOP)
                    begin
                        res_kind = KIND_GOP;
                    end
                    else if (b == CODE_SLICE)
                    begin
                        res_kind = KIND_SLICE;
                    end
                    else
                    begin
                        res_kind = KIND_OTHER;
                    end
                end
            end
            PH_SEQ:
            begin
                if (count_reg != SEQ_STORED)
                begin
                    payload_wr = 1'b1;
                    count_next = count_reg + 2'd1;
                end
                else
                begin
                    // The last payload byte is used straight from the input.
                    res_valid     = 1'b1;
                    res_kind      = KIND_SEQ;
                    res_code      = CODE_SEQ;
                    res_width     = {payload_reg[0], payload_reg[1][7:4]};
                    res_height    = {payload_reg[1][3:0], payload_reg[2]};
                    res_rate      = (!b[3] && (b[2:0] != 3'd0)) ? (b[2:0] - 3'd1)
                                                                : RATE_DEFAULT;
                    phase_next    = PH_SCAN;
                    count_next    = 2'd0;
                    zero_run_next = 2'd0;
                end
            end
            PH_PIC:
            begin
                if (count_reg == 2'd0)
                begin
                    // First picture payload byte carries nothing reported.
                    count_next = 2'd1;
                end
                else
                begin
                    res_valid     = 1'b1;
                    res_kind      = KIND_PIC;
                    res_code      = CODE_PIC;
                    res_pic       = b[5] ? PIC_UNKNOWN : b[4:3];
                    phase_next    = PH_SCAN;
                    count_next    = 2'd0;
                    zero_run_next = 2'd0;
                end
            end
            PH_SCAN:
            begin
                // The zero run saturates at two, so longer runs still match.
                if (b == BYTE_ZERO)
                begin
                    if (zero_run_reg != 2'd2)
                    begin
                        zero_run_next = zero_run_reg + 2'd1;
                    end
                end
                else if (b == BYTE_PREFIX && zero_run_reg == 2'd2)
                begin
                    zero_run_next = 2'd0;
                    phase_next    = PH_CODE;
                end
                else
                begin
                    zero_run_next = 2'd0;
                end
            end
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_valid;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            kind_reg   <= res_kind;
            code_reg   <= res_code;
            width_reg  <= res_width;
            height_reg <= res_height;
            rate_reg   <= res_rate;
            pic_reg    <= res_pic;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tdata  = {3'd0, pic_reg, rate_reg, height_reg, width_reg, code_reg};

    // Checks on the parse state and the two register stages.
    `VSCP_ASSERT_ALWAYS(a_zero_run_sat, zero_run_reg != 2'd3, "zero run passed two")
    `VSCP_ASSERT_SAME(a_count_idle, (phase_reg == PH_SCAN) || (phase_reg == PH_CODE),
        count_reg == 2'd0, "payload count not cleared outside a header")
    `VSCP_ASSERT_SAME(a_pic_count, phase_reg == PH_PIC, count_reg <= 2'd1,
        "picture payload count out of range")
    `VSCP_ASSERT_NEXT(a_in_hold, in_valid_reg && !advance,
        in_valid_reg && $stable(in_byte_reg), "held byte lost before parsing")
    `VSCP_ASSERT_SAME(a_out_source, $rose(out_valid_reg), $past(in_valid_reg),
        "result appeared without a parsed byte")

endmodule

`default_nettype wire

// ===== test/video_start_code_header_parser_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the video start code header parser core
// Feeds byte streams with start codes, headers and noise into the parser,
// predicts every unit report and checks each one field by field under
// several flow-control patterns, including a long receiver hold-off.
// ----------------------------------------------------------------------------

module video_start_code_header_parser_core_test;

    import vscp_pkg::*;

    // Timing of the run.
    localparam int RESET_CYCLES = 12;
    localparam int HOLD_CYCLES  = 150;   // long receiver hold-off
    localparam int SETTLE_CYCLES = 8;    // pipeline is two registers deep
    localparam int IDLE_LIMIT   = 1000;  // cycles with no transaction at all
    localparam int PHASE_BYTES  = 85;

    // A start code needs at least this many zero bytes before the 01 byte.
    localparam logic [1:0] ZERO_RUN_MAX = 2'd2;

    // Picture coding types beyond the unknown one.
    localparam logic [1:0] PIC_I = 2'd1;
    localparam logic [1:0] PIC_B = 2'd3;

    // One unit report, as it leaves the parser.
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  code;
        logic [11:0] width;
        logic [11:0] height;
        logic [2:0]  rate;
        logic [1:0]  pic;
    } unit_report_t;

    // One row of the directed stream. Where typed is set, the row carries
    // its own expectation instead of asking the header model.
    typedef struct packed {
        logic [7:0]   stream_byte;
        logic         typed;
        logic         has_unit;
        unit_report_t unit;
    } stim_row_t;

    localparam unit_report_t NO_UNIT = '0;
    localparam unit_report_t SEQ_MAX_UNIT =
        '{KIND_SEQ, CODE_SEQ, 12'hFFF, 12'hFFF, RATE_DEFAULT, PIC_UNKNOWN};
    localparam unit_report_t GOP_UNIT =
        '{KIND_GOP, CODE_GOP, 12'h000, 12'h000, 3'd0, PIC_UNKNOWN};
    localparam unit_report_t PIC_UNKNOWN_UNIT =
        '{KIND_PIC, CODE_PIC, 12'h000, 12'h000, 3'd0, PIC_UNKNOWN};
    localparam unit_report_t SLICE_UNIT =
        '{KIND_SLICE, CODE_SLICE, 12'h000, 12'h000, 3'd0, PIC_UNKNOWN};
    localparam unit_report_t OTHER_FF_UNIT =
        '{KIND_OTHER, 8'hFF, 12'h000, 12'h000, 3'd0, PIC_UNKNOWN};

    localparam int DIRECTED_COUNT = 27;
    localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // Sequence header with every width and height bit set: widest frame, rate
        // code 15 falls back to the 60 fps index.
        '{8'h00, 1'b0, 1'b0, NO_UNIT},
        '{8'h00, 1'b0, 1'b0, NO_UNIT},
        '{8'h01, 1'b0, 1'b0, NO_UNIT},
        '{8'hB3, 1'b0, 1'b0, NO_UNIT},
        '{8'hFF, 1'b0, 1'b0, NO_UNIT},
        '{8'hFF, 1'b0, 1'b0, NO_UNIT},
        '{8'hFF, 1'b0, 1'b0, NO_UNIT},
        '{8'h0F, 1'b1, 1'b1, SEQ_MAX_UNIT},
        // Three zeros before the 01 byte still make a start code.
        '{8'h00, 1'b0, 1'b0, NO_UNIT},
        '{8'h00, 1'b0, 1'b0, NO_UNIT},
        '{8'h00, 1'b0, 1'b0, NO_UNIT},
        '{8'h01, 1'b0, 1'b0, NO_UNIT},
        '{8'hB8, 1'b1, 1'b1, GOP_UNIT},
        // Picture header whose payload looks like a start code; it must
        // not be scanned, and type zero reports as unknown.
        '{8'h00, 1'b0, 1'b0, NO_UNIT},
        '{8'h00, 1'b0, 1'b0, NO_UNIT},
        '{8'h01, 1'b0, 1'b0, NO_UNIT},
        '{8'h00, 1'b0, 1'b0, NO_UNIT},
        '{8'h00, 1'b0, 1'b0, NO_UNIT},
        '{8'h01, 1'b1, 1'b1, PIC_UNKNOWN_UNIT},
        // Slice right after a header: the zero run starts over.
        '{8'h00, 1'b0, 1'b0, NO_UNIT},
        '{8'h00, 1'b0, 1'b0, NO_UNIT},
        '{8'h01, 1'b0, 1'b0, NO_UNIT},
        '{8'h01, 1'b1, 1'b1, SLICE_UNIT},
        // Largest code byte reports as an other unit.
        '{8'h00, 1'b0, 1'b0, NO_UNIT},
        '{8'h00, 1'b0, 1'b0, NO_UNIT},
        '{8'h01, 1'b0, 1'b0, NO_UNIT},
        '{8'hFF, 1'b1, 1'b1, OTHER_FF_UNIT}
    };

    // DUT connections; every input is known from time zero.
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    // Flow-control knobs, in percent, changed between phases.
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    // The sender flips this to ask the receiver for a long hold-off.
    logic hold_token = 1'b0;

    // Header model state.
    logic [1:0] zero_run_m;
    phase_t     phase_m;
    logic [1:0] stored_m;
    logic [7:0] stash_m [3];

    unit_report_t pending_units [$];

    int mismatch_count = 0;
    int bytes_sent = 0;
    int units_checked = 0;
    int kind_seen [5] = '{0, 0, 0, 0, 0};
    int idle_cycles = 0;

    video_start_code_header_parser_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Advances the header model by one stream byte and tells whether the
    // byte completes a unit.
    task automatic parse_byte(input logic [7:0] b, output bit got,
                              output unit_report_t unit);
        logic [3:0] rate_code;
        logic [2:0] pic_code;
        got = 1'b0;
        unit = NO_UNIT;
        case (phase_m)
            PH_CODE:
            begin
                zero_run_m = 2'd0;
                stored_m = 2'd0;
                if (b == CODE_SEQ)
                begin
                    phase_m = PH_SEQ;
                end
                else if (b == CODE_PIC)
                begin
                    phase_m = PH_PIC;
                end
                else
                begin
                    phase_m = PH_SCAN;
                    got = 1'b1;
                    unit.code = b;
                    if (b == CODE_GOP)
                        unit.kind = KIND_GOP;
                    else if (b == CODE_SLICE)
                        unit.kind = KIND_SLICE;
                    else
                        unit.kind = KIND_OTHER;
                end
            end
            PH_SEQ:
            begin
                if (stored_m < SEQ_STORED)
                begin
                    stash_m[stored_m] = b;
                    stored_m = stored_m + 2'd1;
                end
                else
                begin
                    // The last payload byte is used straight from the stream.
                    rate_code = b[3:0];
                    got = 1'b1;
                    unit.kind = KIND_SEQ;
                    unit.code = CODE_SEQ;
                    unit.width = {stash_m[0], stash_m[1][7:4]};
                    unit.height = {stash_m[1][3:0], stash_m[2]};
                    if (rate_code >= 4'd1 && rate_code <= 4'd7)
                        unit.rate = 3'(rate_code - 4'd1);
                    else
                        unit.rate = RATE_DEFAULT;
                    phase_m = PH_SCAN;
                    stored_m = 2'd0;
                    zero_run_m = 2'd0;
                end
            end
            PH_PIC:
            begin
                if (stored_m == 2'd0)
                begin
                    stash_m[0] = b;
                    stored_m = 2'd1;
                end
                else
                begin
                    pic_code = b[5:3];
                    got = 1'b1;
                    unit.kind = KIND_PIC;
                    unit.code = CODE_PIC;
                    if (pic_code >= 3'(PIC_I) && pic_code <= 3'(PIC_B))
                        unit.pic = pic_code[1:0];
                    else
                        unit.pic = PIC_UNKNOWN;
                    phase_m = PH_SCAN;
                    stored_m = 2'd0;
                    zero_run_m = 2'd0;
                end
            end
            default:
            begin
                phase_m = PH_SCAN;
                if (b == BYTE_ZERO)
                begin
                    if (zero_run_m < ZERO_RUN_MAX)
                        zero_run_m = zero_run_m + 2'd1;
                end
                else if (b == BYTE_PREFIX && zero_run_m == ZERO_RUN_MAX)
                begin
                    zero_run_m = 2'd0;
                    phase_m = PH_CODE;
                end
                else
                begin
                    zero_run_m = 2'd0;
                end
            end
        endcase
    endtask

    // Offers one byte, waits for its transaction and records what it should
    // cause. Gaps come before the byte, so tvalid only changes once a step.
    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input bit has_unit = 1'b0,
                             input unit_report_t typed_unit = '0);
        bit got;
        unit_report_t predicted;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        parse_byte(b, got, predicted);
        if (typed)
        begin
            if (has_unit)
                pending_units.push_back(typed_unit);
        end
        else if (got)
        begin
            pending_units.push_back(predicted);
        end
        bytes_sent++;
    endtask

    // Payload and noise bytes lean toward values that matter to the scanner.
    function automatic logic [7:0] noisy_byte();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            return BYTE_ZERO;
        if (pick < 35)
            return BYTE_PREFIX;
        if (pick < 45)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_prefix();
        int zeros;
        zeros = $urandom_range(2, 4);
        repeat (zeros) send_byte(BYTE_ZERO);
        send_byte(BYTE_PREFIX);
    endtask

    // Mostly well-formed units with random content; the rest is noise that
    // includes broken prefixes.
    task automatic send_random_unit();
        int pick;
        int n;
        logic [2:0] pic_code;
        pick = $urandom_range(0, 99);
        if (pick >= 80)
        begin
            n = $urandom_range(1, 6);
            repeat (n) send_byte(noisy_byte());
        end
        else
        begin
            send_prefix();
            if (pick < 20)
            begin
                send_byte(CODE_SEQ);
                repeat (3) send_byte(noisy_byte());
                send_byte(8'($urandom_range(0, 255)));
            end
            else if (pick < 40)
            begin
                send_byte(CODE_PIC);
                send_byte(noisy_byte());
                pic_code = 3'($urandom_range(0, 7));
                send_byte({2'($urandom_range(0, 3)), pic_code, 3'($urandom_range(0, 7))});
            end
            else if (pick < 50)
            begin
                send_byte(CODE_GOP);
            end
            else if (pick < 60)
            begin
                send_byte(CODE_SLICE);
            end
            else
            begin
                send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic run_random(input int target);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < target)
            send_random_unit();
    endtask

    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_units.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Stimulus: directed table, a forced stall, then four random phases.
    initial
    begin : stimulus
        int row;
        zero_run_m = 2'd0;
        phase_m = PH_SCAN;
        stored_m = 2'd0;
        stash_m = '{8'h00, 8'h00, 8'h00};
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < DIRECTED_COUNT; row++)
            send_byte(DIRECTED_ROWS[row].stream_byte, DIRECTED_ROWS[row].typed,
                      DIRECTED_ROWS[row].has_unit, DIRECTED_ROWS[row].unit);

        // Slices back to back while the receiver holds off fill both
        // registers, so the input side has to stall.
        hold_token <= ~hold_token;
        repeat (6)
        begin
            send_prefix();
            send_byte(CODE_SLICE);
        end
        wait_for_drain();

        run_random(PHASE_BYTES);

        src_idle_pct <= 54;
        sink_stall_pct <= 0;
        run_random(PHASE_BYTES);

        src_idle_pct <= 0;
        sink_stall_pct <= 54;
        run_random(PHASE_BYTES);

        src_idle_pct <= 34;
        sink_stall_pct <= 34;
        run_random(PHASE_BYTES);

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d stream bytes and checked %0d unit reports: %0d sequence, %0d GOP,",
                 bytes_sent, units_checked, kind_seen[KIND_SEQ], kind_seen[KIND_GOP]);
        $display("%0d picture, %0d slice, %0d other, under four flow-control mixes and a hold-off.",
                 kind_seen[KIND_PIC], kind_seen[KIND_SLICE], kind_seen[KIND_OTHER]);
        if (pending_units.size() != 0)
        begin
            $error("%0d unit reports never arrived", pending_units.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off whenever the sender
    // flips the token.
    initial
    begin : sink_drive
        logic hold_seen;
        int hold_left;
        hold_seen = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    // Each accepted report is compared with the oldest expectation.
    always @(posedge clk)
    begin : report_check
        unit_report_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_units.size() == 0)
            begin
                $error("unexpected unit report: kind %0d code 0x%02h",
                       m_axis_tuser, m_axis_tdata[7:0]);
                mismatch_count++;
            end
            else
            begin
                want = pending_units.pop_front();
                check_field("unit_kind", 32'(want.kind), 32'(m_axis_tuser));
                check_field("code_value", 32'(want.code), 32'(m_axis_tdata[7:0]));
                check_field("frame_width", 32'(want.width), 32'(m_axis_tdata[19:8]));
                check_field("frame_height", 32'(want.height), 32'(m_axis_tdata[31:20]));
                check_field("rate_index", 32'(want.rate), 32'(m_axis_tdata[34:32]));
                check_field("picture_kind", 32'(want.pic), 32'(m_axis_tdata[36:35]));
                if (want.kind <= KIND_OTHER)
                    kind_seen[want.kind]++;
            end
            units_checked++;
        end
    end

    // Watchdog: too long without any transaction ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

endmodule
